// File: sv/hfs_pkg.sv
`default_nettype none

package hfs_pkg;

  // field widths fixed by the interface
  localparam int unsigned GATE_W  = 11;
  localparam int unsigned COUNT_W = 11;

  // free map is stored as words of this many gates
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WORD_LSB = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_DONE
  } hfs_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_write;  // write an all-free word at the pointer, advance
    logic load;       // capture request, point at the limit's word
    logic step;       // move to the next lower word
    logic take;       // claim the found gate
    logic close;      // no free gate: close the block
    logic emit;       // move the result into the output register
  } hfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic closed;
    logic hit;
    logic ptr_zero;
  } hfs_status_t;

endpackage

`default_nettype wire

// File: sv/highest_free_slot_at_or_below.sv
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   limit_gate_i
// out       output     out_valid_o / out_stall_i granted_o, gate_taken_o,
//                                                granted_total_o, closed_o
// cfg       input      cfg_we_i                  cfg_wdata_i (gate_count)
//
// one request at a time; a request scans the 32-gate words of the free map
// downward from the limit's word, one map read and one test per word, until
// its result is loaded; a request while closed goes straight to its result
// after reset a clearing pass writes all ceil((MAX_GATES+1)/32) words of the
// free map (33 by default), with in_stall_o high; cfg writes are taken meanwhile
// the next request is taken while a result waits in the output register; a
// finished result waits in the search unit until the output register frees up

module highest_free_slot_at_or_below
  import hfs_pkg::*;
#(
  parameter int unsigned MAX_GATES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [GATE_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [GATE_W-1:0]  limit_gate_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    granted_o,
  output logic [GATE_W-1:0]       gate_taken_o,
  output logic [COUNT_W-1:0]      granted_total_o,
  output logic                    closed_o
);

  hfs_cmd_t    cmd;
  hfs_status_t status;

  // sequencer: clearing pass, word scan, result handoff
  hfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // free map, word priority encoder, counter, closed flag, output register
  hfs_dp #(
    .MAX_GATES (MAX_GATES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .limit_gate_i    (limit_gate_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .granted_o       (granted_o),
    .gate_taken_o    (gate_taken_o),
    .granted_total_o (granted_total_o),
    .closed_o        (closed_o)
  );

endmodule

`default_nettype wire

// File: sv/hfs_ram.sv
`default_nettype none

module hfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 33,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/hfs_dp.sv
`default_nettype none

module hfs_dp
  import hfs_pkg::*;
#(
  parameter int unsigned MAX_GATES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [GATE_W-1:0]  cfg_wdata_i,
  input  wire logic [GATE_W-1:0]  limit_gate_i,
  input  wire hfs_cmd_t           cmd_i,
  output hfs_status_t             status_o,
  output logic                    granted_o,
  output logic [GATE_W-1:0]       gate_taken_o,
  output logic [COUNT_W-1:0]      granted_total_o,
  output logic                    closed_o
);

  // bit 0 of word 0 stands for gate 0, which never exists
  localparam int unsigned NWORDS = (MAX_GATES + WORD_W) / WORD_W;
  localparam int unsigned PTR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [GATE_W-1:0] MAX_CLAMP =
    (MAX_GATES > 2047) ? {GATE_W{1'b1}} : GATE_W'(MAX_GATES);
  localparam logic [PTR_W-1:0] LAST_WORD = PTR_W'(NWORDS - 1);

  logic [GATE_W-1:0]   gate_count_q;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [WORD_LSB-1:0] pos_q;
  logic                first_q;
  logic [COUNT_W-1:0]  count_q;
  logic                closed_q;
  logic                res_grant_q;
  logic [GATE_W-1:0]   res_gate_q;

  logic                out_grant_q;
  logic [GATE_W-1:0]   out_gate_q;
  logic [COUNT_W-1:0]  out_total_q;
  logic                out_closed_q;

  logic [GATE_W-1:0]   eff_n;
  logic [GATE_W-1:0]   lim_c;
  logic [WORD_W-1:0]   rdata;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   cand;
  logic [WORD_LSB-1:0] hit_idx;
  logic                hit;
  logic                ram_we;
  logic [WORD_W-1:0]   ram_wdata;
  logic [GATE_W-1:0]   hit_gate;

  // clamp the limit to the gates in use
  always_comb begin
    eff_n = (gate_count_q > MAX_CLAMP) ? MAX_CLAMP : gate_count_q;
    lim_c = (limit_gate_i > eff_n) ? eff_n : limit_gate_i;
  end

  // free bits at or below the limit in the current word
  always_comb begin
    mask = first_q ? ({WORD_W{1'b1}} >> ~pos_q) : {WORD_W{1'b1}};
    if (ptr_q == '0) begin
      mask[0] = 1'b0;
    end
    cand    = rdata & mask;
    hit     = |cand;
    hit_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (cand[i]) begin
        hit_idx = WORD_LSB'(i);
      end
    end
    hit_gate = GATE_W'({ptr_q, hit_idx});
  end

  always_comb begin
    ram_we    = cmd_i.clr_write | cmd_i.take;
    ram_wdata = {WORD_W{1'b1}};
    if (cmd_i.take) begin
      ram_wdata = rdata & ~(WORD_W'(1) << hit_idx);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.clr_write) begin
      ptr_d = ptr_q + 1'b1;
    end else if (cmd_i.load) begin
      ptr_d = PTR_W'(lim_c[GATE_W-1:WORD_LSB]);
    end else if (cmd_i.step) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  hfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_count_q <= GATE_W'(1024);
      ptr_q        <= '0;
      count_q      <= '0;
      closed_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gate_count_q <= cfg_wdata_i;
      end
      ptr_q <= ptr_d;
      if (cmd_i.take && count_q != COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.close) begin
        closed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q       <= lim_c[WORD_LSB-1:0];
      first_q     <= 1'b1;
      res_grant_q <= 1'b0;
      res_gate_q  <= '0;
    end else if (cmd_i.step) begin
      first_q <= 1'b0;
    end
    if (cmd_i.take) begin
      res_grant_q <= 1'b1;
      res_gate_q  <= hit_gate;
    end
    if (cmd_i.emit) begin
      out_grant_q  <= res_grant_q;
      out_gate_q   <= res_gate_q;
      out_total_q  <= count_q;
      out_closed_q <= closed_q;
    end
  end

  assign status_o.clr_last = (ptr_q == LAST_WORD);
  assign status_o.closed   = closed_q;
  assign status_o.hit      = hit;
  assign status_o.ptr_zero = (ptr_q == '0);

  assign granted_o       = out_grant_q;
  assign gate_taken_o    = out_gate_q;
  assign granted_total_o = out_total_q;
  assign closed_o        = out_closed_q;

endmodule

`default_nettype wire

// File: sv/hfs_ctrl.sv
`default_nettype none

module hfs_ctrl
  import hfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire hfs_status_t status_i,
  output hfs_cmd_t         cmd_o
);

  hfs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.closed ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.hit) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DONE;
        end else if (status_i.ptr_zero) begin
          cmd_o.close = 1'b1;
          state_d     = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: test/highest_free_slot_at_or_below_checker.sv
module highest_free_slot_at_or_below_checker
  import hfs_pkg::*;
#(
  parameter int unsigned MAX_GATES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [GATE_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [GATE_W-1:0]  limit_gate_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               granted_i,
  input  wire logic [GATE_W-1:0]  gate_taken_i,
  input  wire logic [COUNT_W-1:0] granted_total_i,
  input  wire logic               closed_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic               granted;
    logic [GATE_W-1:0]  gate;
    logic [COUNT_W-1:0] total;
    logic               closed;
  } grant_t;

  // allocator state as seen from outside
  logic [MAX_GATES:0] gate_free;
  logic [COUNT_W-1:0] grant_count;
  logic               is_closed;
  logic [GATE_W-1:0]  gate_count;

  grant_t      expected_grants[$];
  int unsigned mismatch_count;

  assign fail_count_o = mismatch_count;

  // highest free gate at or below the clamped limit, claimed at once
  function automatic grant_t allocate_gate(input logic [GATE_W-1:0] limit);
    grant_t      res;
    int unsigned top_gate;
    int          k;
    res = '0;
    if (!is_closed) begin
      top_gate = (gate_count > MAX_GATES) ? MAX_GATES : gate_count;
      if (limit < top_gate) top_gate = limit;
      for (k = top_gate; k >= 1; k--) begin
        if (gate_free[k]) begin
          res.granted = 1'b1;
          res.gate    = GATE_W'(k);
          break;
        end
      end
      if (res.granted) begin
        gate_free[res.gate] = 1'b0;
        if (grant_count != COUNT_MAX) grant_count = grant_count + 1'b1;
      end else begin
        is_closed = 1'b1;
      end
    end
    res.total  = grant_count;
    res.closed = is_closed;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      gate_free      = '1;
      gate_free[0]   = 1'b0;
      grant_count    = '0;
      is_closed      = 1'b0;
      gate_count     = GATE_W'(1024);
      mismatch_count = 0;
      expected_grants.delete();
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) gate_count = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_grants.push_back(allocate_gate(limit_gate_i));
      if (out_valid_i && !out_stall_i) begin
        seen = {granted_i, gate_taken_i, granted_total_i, closed_i};
        if (expected_grants.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: granted %0b gate %0d total %0d closed %0b",
                     seen.granted, seen.gate, seen.total, seen.closed);
        end else begin
          want = expected_grants.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch: expected granted %0b gate %0d total %0d closed %0b,",
                        " got granted %0b gate %0d total %0d closed %0b"},
                       want.granted, want.gate, want.total, want.closed,
                       seen.granted, seen.gate, seen.total, seen.closed);
          end
        end
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

// File: test/highest_free_slot_at_or_below_tb.sv
module highest_free_slot_at_or_below_tb;
  import hfs_pkg::*;

  localparam int unsigned MAX_GATES = 1024;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [GATE_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [GATE_W-1:0]  limit_gate_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               granted_o;
  logic [GATE_W-1:0]  gate_taken_o;
  logic [COUNT_W-1:0] granted_total_o;
  logic               closed_o;

  int unsigned fail_count;
  int unsigned pending;

  // idling controls for sender and receiver; quiet and burst_phase act on both
  logic        quiet = 1'b0;        // no idling on either side
  logic        burst_phase = 1'b0;  // sender never pauses, receiver holds off once
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  always #2 clk_i = ~clk_i;

  highest_free_slot_at_or_below #(
    .MAX_GATES(MAX_GATES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .limit_gate_i   (limit_gate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .gate_taken_o   (gate_taken_o),
    .granted_total_o(granted_total_o),
    .closed_o       (closed_o)
  );

  highest_free_slot_at_or_below_checker #(
    .MAX_GATES(MAX_GATES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .limit_gate_i   (limit_gate_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_i      (granted_o),
    .gate_taken_i   (gate_taken_o),
    .granted_total_i(granted_total_o),
    .closed_i       (closed_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side: random stalls, none while quiet, one long hold-off
  // when the burst starts so the block backs up into its input
  always @(posedge clk_i) begin
    if (burst_phase && !hold_used) begin
      hold_used   <= 1'b1;
      hold_left   <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 12);
    end
  end

  // offer one request and hold it until its transfer; valid stays high
  // afterwards so back-to-back requests need no gap
  task automatic send_request(input logic [GATE_W-1:0] limit);
    if (!quiet && !burst_phase && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    limit_gate_i <= limit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender pauses until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_gate_count(input logic [GATE_W-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned grants_made;   // gates taken so far
    int unsigned gate_total;
    int unsigned usable;
    int          phase;
    int          i;
    logic [GATE_W-1:0] limit;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // gate count at its reset value: top gate, then limit above the range
    send_request(11'd1024);
    send_request(11'd2047);
    drain();
    // single gate in use, limit clamped down to it
    write_gate_count(11'd1);
    send_request(11'd2047);
    drain();
    write_gate_count(11'd2);
    send_request(11'd2);
    drain();
    // gate count above the maximum saturates; map keeps earlier grants
    write_gate_count(11'd2047);
    send_request(11'd1024);
    send_request(11'd3);
    send_request(11'd1536);
    send_request(11'd512);
    send_request(11'd512);   // falls to the next lower gate
    send_request(11'd4);
    send_request(11'd33);    // map word boundaries
    send_request(11'd32);
    send_request(11'd31);
    send_request(11'd64);
    send_request(11'd65);
    drain();
    grants_made = 15;

    // random phases; a limit whose clamped value exceeds the gates already
    // taken always finds a free gate, so the block stays open throughout
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 2) gate_total = 1024;
      else gate_total = $urandom_range(2047, grants_made + 120);
      write_gate_count(GATE_W'(gate_total));
      usable = (gate_total > MAX_GATES) ? MAX_GATES : gate_total;
      if (phase == 1) burst_phase <= 1'b1;
      if (phase == 3) quiet <= 1'b1;
      for (i = 0; i < 100; i++) begin
        if (phase == 1 && i == 40) burst_phase <= 1'b0;
        case ($urandom_range(3))
          0:       limit = GATE_W'($urandom_range(2047, grants_made + 1));
          3:       limit = GATE_W'($urandom_range(grants_made + 8, grants_made + 1));
          default: limit = GATE_W'($urandom_range(usable, grants_made + 1));
        endcase
        send_request(limit);
        grants_made++;
      end
      if (phase == 3) quiet <= 1'b0;
      drain();
    end

    // closing: either no gates in use or a limit of zero
    if ($urandom_range(1)) begin
      write_gate_count('0);
      send_request(11'd1024);
      send_request('0);
    end else begin
      send_request('0);
      drain();
      write_gate_count('0);
      send_request(11'd1024);
    end
    // everything after the close is refused
    send_request(11'd2047);
    send_request(11'd1);
    for (i = 0; i < 5; i++) send_request(GATE_W'($urandom_range(2047, 0)));
    drain();

    // room for anything the block might still emit
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("highest_free_slot_at_or_below test passed");
    end else begin
      $display("highest_free_slot_at_or_below test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("highest_free_slot_at_or_below test failed");
    $finish;
  end

endmodule

// File: files.f
sv/hfs_pkg.sv
sv/hfs_ram.sv
sv/hfs_dp.sv
sv/hfs_ctrl.sv
sv/highest_free_slot_at_or_below.sv
test/highest_free_slot_at_or_below_checker.sv
test/highest_free_slot_at_or_below_tb.sv
